@@ rtl/core/ret_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle exclusion table package
// Request kinds and the types shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package ret_pkg;

  typedef logic [1:0] req_kind_t;

  localparam req_kind_t REQ_PROBE = 2'd0;
  localparam req_kind_t REQ_PLACE = 2'd1;
  localparam req_kind_t REQ_FORCE = 2'd2;
  localparam req_kind_t REQ_CLEAR = 2'd3;

endpackage : ret_pkg
`default_nettype wire

@@ rtl/core/ret_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle exclusion table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ret_req_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  ret_pkg::req_kind_t           req_type;
  logic signed [COORD_BITS-1:0] left_edge;
  logic signed [COORD_BITS-1:0] right_edge;
  logic signed [COORD_BITS-1:0] bottom_edge;
  logic signed [COORD_BITS-1:0] top_edge;

  modport source (output valid, req_type, left_edge, right_edge, bottom_edge, top_edge,
                  input ready);
  modport sink (input valid, req_type, left_edge, right_edge, bottom_edge, top_edge,
                output ready);
endinterface : ret_req_if

interface ret_rsp_if #(
  parameter int CNT_BITS = 9
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                stored;
  logic                table_full;
  logic [CNT_BITS-1:0] entries_after;

  modport source (output valid, hit, stored, table_full, entries_after, input ready);
  modport sink (input valid, hit, stored, table_full, entries_after, output ready);
endinterface : ret_rsp_if
`default_nettype wire

@@ rtl/core/ret_overlap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle overlap comparator
// Strict overlap test of a query rectangle against one stored rectangle.
// ----------------------------------------------------------------------------
module ret_overlap #(
  parameter int COORD_BITS = 16
) (
  input  wire logic [4*COORD_BITS-1:0] query,
  input  wire logic [4*COORD_BITS-1:0] entry,
  output logic                         overlap
);

  // Packing order, high to low: left, right, bottom, top.
  logic signed [COORD_BITS-1:0] q_left, q_right, q_bottom, q_top;
  logic signed [COORD_BITS-1:0] e_left, e_right, e_bottom, e_top;

  assign {q_left, q_right, q_bottom, q_top} = query;
  assign {e_left, e_right, e_bottom, e_top} = entry;

  // Touching edges do not count as an overlap.
  assign overlap = (q_right > e_left) && (q_left < e_right) &&
                   (q_top > e_bottom) && (q_bottom < e_top);

endmodule : ret_overlap
`default_nettype wire

@@ rtl/core/rectangle_exclusion_table.sv @@
`default_nettype none
// A probe or place compares its query against the stored entries before its
// result is registered; a force insert or clear gives its result without a scan.
// The table works on one item at a time, and a new request is taken only in the
// idle state; a hit ends the scan early.
// Reset clears the entry count and the handshake state; the store is not cleared.
// ----------------------------------------------------------------------------
// Rectangle exclusion table
// Stores axis-aligned rectangles and tests new ones for strict overlap.
// ----------------------------------------------------------------------------
module rectangle_exclusion_table #(
  parameter int DEPTH      = 256,
  parameter int COORD_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  ret_req_if.sink  req,
  ret_rsp_if.source rsp
);

  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int RECT_BITS = 4 * COORD_BITS;

  // Controller states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state;
  logic [CNT_BITS-1:0] count;       // number of valid entries in the store
  logic [CNT_BITS-1:0] issue_idx;   // next entry to read during a scan
  logic                pend;        // a read issued last cycle has data this cycle
  logic                hit_flag;
  ret_pkg::req_kind_t  kind;
  logic [RECT_BITS-1:0] query;

  // Output register: it holds a finished result until the sink takes it, so the
  // controller can already work on the next item.
  logic                rsp_valid;
  logic                rsp_hit;
  logic                rsp_stored;
  logic                rsp_full;
  logic [CNT_BITS-1:0] rsp_count;

  // The rectangle store: one write port, one registered read port.
  logic [RECT_BITS-1:0] store [DEPTH];
  logic [RECT_BITS-1:0] rd_data;
  logic                 rd_en;
  logic                 wr_en;

  logic overlap;
  logic scan_done;
  logic out_free;
  logic do_insert;
  logic room;

  ret_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .query  (query),
    .entry  (rd_data),
    .overlap(overlap)
  );

  always_comb begin
    rd_en     = (state == ST_SCAN) && (issue_idx < count);
    // The scan ends at the first overlap, or once every entry has been compared.
    scan_done = (state == ST_SCAN) && ((pend && overlap) || (!pend && !rd_en));
    out_free  = !rsp_valid || rsp.ready;
    do_insert = (kind == ret_pkg::REQ_FORCE) || ((kind == ret_pkg::REQ_PLACE) && !hit_flag);
    room      = count < CNT_BITS'(DEPTH);
    wr_en     = (state == ST_FINISH) && out_free && do_insert && room;
  end

  // Only entries below the entry count are ever read, and those were written.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[issue_idx[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count[IDX_BITS-1:0]] <= query;
    end
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issue_idx <= '0;
      pend      <= 1'b0;
      hit_flag  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // A new result is loaded in the cycle the old one leaves, if any.
      if ((state == ST_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            kind      <= req.req_type;
            query     <= {req.left_edge, req.right_edge, req.bottom_edge, req.top_edge};
            hit_flag  <= 1'b0;
            pend      <= 1'b0;
            issue_idx <= '0;
            // Only probe and place compare against the stored rectangles.
            if ((req.req_type == ret_pkg::REQ_PROBE) ||
                (req.req_type == ret_pkg::REQ_PLACE)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_BITS'(1);
          end
          pend <= rd_en;
          if (pend && overlap) begin
            hit_flag <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Wait here until the output register can take the result.
          if (out_free) begin
            rsp_hit    <= hit_flag;
            rsp_stored <= do_insert && room;
            rsp_full   <= do_insert && !room;
            if (kind == ret_pkg::REQ_CLEAR) begin
              count     <= '0;
              rsp_count <= '0;
            end else if (wr_en) begin
              count     <= count + CNT_BITS'(1);
              rsp_count <= count + CNT_BITS'(1);
            end else begin
              rsp_count <= count;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.hit           = rsp_hit;
  assign rsp.stored        = rsp_stored;
  assign rsp.table_full    = rsp_full;
  assign rsp.entries_after = rsp_count;

endmodule : rectangle_exclusion_table
`default_nettype wire
